/* hw/rtl/pcm_pkg.sv */
// Package for the nearest palette colour match block.
// Shared widths, codes, state type and the compare result struct.
// No dependencies.
`default_nettype none

package pcm_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CHAN_W              = 8;
  localparam int COLOUR_W            = 3 * CHAN_W;
  localparam int IDX_W               = 8;
  localparam int IDX_SPAN            = 1 << IDX_W;
  localparam int DIST_W              = 11;
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(1024);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } pcm_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pcm_state_e;

  typedef struct packed {
    logic              zero;
    logic              closer;
    logic [DIST_W-1:0] distance;
  } pcm_cmp_t;

endpackage

`default_nettype wire

/* hw/rtl/nearest_palette_color_match.sv */
// Nearest palette colour match, top level. Uses pcm_pkg, pcm_palette_ram, pcm_l1_dist.
// A write transaction stores one palette entry and gives no result.
// A query reads entries 1 to min(PALETTE_ENTRIES,256)-2 one per cycle from the palette
// memory through one L1 distance unit; an exact hit ends the scan early. The single memory
// read port sets that rate. A finished result waits in an output register, so a new
// transaction is taken while it is still stalled. Entries never written must not be
// scanned.
`default_nettype none

module nearest_palette_color_match
  import pcm_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              command_i,
  input  wire logic [IDX_W-1:0]  entry_index_i,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic              exact_only_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   found_o,
  output logic      [IDX_W-1:0]  match_index_o
);

  localparam int DEPTH = (PALETTE_ENTRIES > IDX_SPAN) ? IDX_SPAN : PALETTE_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 2);

  pcm_state_e state_q, state_d;

  logic              in_accept, wr_en, query_start;
  logic              scan_hit, scan_end, upd, out_load;
  logic              issue_act_q, issue_act_d;
  logic [AW-1:0]     issue_ptr_q, issue_ptr_d;
  logic              ev_valid_q, ev_valid_d;
  logic [AW-1:0]     ev_idx_q;
  logic [CHAN_W-1:0] qr_q, qg_q, qb_q;
  logic              exact_q;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic              have_q, have_d;
  logic              res_found_q, res_found_d;
  logic [AW-1:0]     res_idx_q, res_idx_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q;
  logic [IDX_W-1:0]  match_index_q;
  logic [COLOUR_W-1:0] rdata;
  pcm_cmp_t          cmp;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign wr_en       = in_accept && (command_i == CMD_WRITE)
                       && (32'(entry_index_i) < PALETTE_ENTRIES);
  assign query_start = in_accept && (command_i == CMD_QUERY);

  pcm_palette_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (entry_index_i[AW-1:0]),
    .wdata_i ({red_i, green_i, blue_i}),
    .raddr_i (issue_ptr_q),
    .rdata_o (rdata)
  );

  pcm_l1_dist u_dist (
    .entry_i     (rdata),
    .red_i       (qr_q),
    .green_i     (qg_q),
    .blue_i      (qb_q),
    .best_dist_i (best_dist_q),
    .cmp_o       (cmp)
  );

  assign scan_hit = ev_valid_q && cmp.zero;
  assign scan_end = ev_valid_q && (cmp.zero || (ev_idx_q == LAST));
  assign upd      = ev_valid_q && !exact_q && cmp.closer;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    issue_ptr_d = issue_ptr_q;
    issue_act_d = issue_act_q;
    ev_valid_d  = 1'b0;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    have_d      = have_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (query_start) begin
          issue_ptr_d = AW'(1);
          issue_act_d = 1'b1;
          best_dist_d = DIST_START;
          best_idx_d  = '0;
          have_d      = 1'b0;
        end
      end
      ST_SCAN: begin
        ev_valid_d = issue_act_q && !scan_end;
        if (issue_act_q) begin
          issue_ptr_d = issue_ptr_q + AW'(1);
          if (issue_ptr_q == LAST) issue_act_d = 1'b0;
        end
        if (upd) begin
          best_dist_d = cmp.distance;
          best_idx_d  = ev_idx_q;
          have_d      = 1'b1;
        end
        if (scan_end) begin
          issue_act_d = 1'b0;
          res_found_d = scan_hit || have_q || upd;
          res_idx_d   = scan_hit ? ev_idx_q : (upd ? ev_idx_q : best_idx_q);
        end
      end
      ST_FINISH: begin
        if (out_load) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_act_q <= 1'b0;
      ev_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_act_q <= issue_act_d;
      ev_valid_q  <= ev_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_ptr_q <= issue_ptr_d;
    ev_idx_q    <= issue_ptr_q;
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    have_q      <= have_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    if (query_start) begin
      qr_q    <= red_i;
      qg_q    <= green_i;
      qb_q    <= blue_i;
      exact_q <= exact_only_i;
    end
    if (out_load) begin
      found_q       <= res_found_q;
      match_index_q <= res_found_q ? IDX_W'(res_idx_q) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = match_index_q;

endmodule

`default_nettype wire

/* hw/rtl/pcm_palette_ram.sv */
// Palette storage: one write port, one registered read port.
// Depends on pcm_pkg for the colour width.
`default_nettype none

module pcm_palette_ram
  import pcm_pkg::*;
#(
  parameter int DEPTH = PALETTE_ENTRIES_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire logic [COLOUR_W-1:0] wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output logic      [COLOUR_W-1:0] rdata_o
);

  logic [COLOUR_W-1:0] mem_q [DEPTH];
  logic [COLOUR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/pcm_l1_dist.sv */
// Shared L1 distance and compare unit: |dr| + |dg| + |db| against the best so far.
// Depends on pcm_pkg for widths and the compare struct.
`default_nettype none

module pcm_l1_dist
  import pcm_pkg::*;
(
  input  wire logic [COLOUR_W-1:0] entry_i,
  input  wire logic [CHAN_W-1:0]   red_i,
  input  wire logic [CHAN_W-1:0]   green_i,
  input  wire logic [CHAN_W-1:0]   blue_i,
  input  wire logic [DIST_W-1:0]   best_dist_i,
  output pcm_cmp_t                 cmp_o
);

  logic [CHAN_W-1:0] er, eg, eb;
  logic [CHAN_W-1:0] dr, dg, db;
  logic [DIST_W-1:0] sum;

  assign er = entry_i[3*CHAN_W-1:2*CHAN_W];
  assign eg = entry_i[2*CHAN_W-1:CHAN_W];
  assign eb = entry_i[CHAN_W-1:0];

  assign dr = (er > red_i)   ? (er - red_i)   : (red_i - er);
  assign dg = (eg > green_i) ? (eg - green_i) : (green_i - eg);
  assign db = (eb > blue_i)  ? (eb - blue_i)  : (blue_i - eb);

  assign sum = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);

  always_comb begin
    cmp_o.distance = sum;
    cmp_o.zero     = (sum == '0);
    cmp_o.closer   = (sum < best_dist_i);
  end

endmodule

`default_nettype wire
